[rtl/four_point_homography_solver_defines.svh]
// Assertion macros shared by the solver RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FOUR_POINT_HOMOGRAPHY_SOLVER_DEFINES_SVH
`define FOUR_POINT_HOMOGRAPHY_SOLVER_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define FHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define FHS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/fhs_pkg.sv]
// Shared types, constants and the sequencer state type of the solver.
// No dependencies.
package fhs_pkg;

  localparam int WORD_W     = 64;
  localparam int VAL_W      = 48;
  localparam int ROWS       = 8;
  localparam int COLS       = 9;
  localparam int MEM_DEPTH  = ROWS * COLS;
  localparam int ADDR_W     = 7;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  localparam word_t SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t VMAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam word_t VMIN64 = -VMAX64 - 64'sd1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_MAJOR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b1;

  typedef enum logic [1:0] {
    SRC_H,
    SRC_ONE,
    SRC_ZERO
  } src_kind_t;

  typedef struct packed {
    src_kind_t  kind;
    logic [2:0] hidx;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD,
    S_PRD, S_PCMP,
    S_SW0, S_SW1, S_SW2, S_SW3,
    S_E0, S_E1, S_EDIV, S_E2, S_E3, S_EMUL,
    S_B0, S_B1, S_B2, S_B3, S_BMUL, S_B4, S_B5, S_BDIV,
    S_EMIT
  } fhs_state_t;

  // Source of matrix entry (r,c); n4 selects the 4x4 layout.
  function automatic entry_t entry_of(logic [2:0] r, logic [2:0] c, logic n4);
    entry_t e;
    e.kind = SRC_H;
    e.hidx = 3'd0;
    unique case ({n4, r, c})
      7'b0_000_000: e.hidx = 3'd0;
      7'b0_000_001: e.hidx = 3'd1;
      7'b0_000_010: e.hidx = 3'd2;
      7'b0_001_000: e.hidx = 3'd3;
      7'b0_001_001: e.hidx = 3'd4;
      7'b0_001_010: e.hidx = 3'd5;
      7'b0_010_000: e.hidx = 3'd6;
      7'b0_010_001: e.hidx = 3'd7;
      7'b0_010_010: e.kind = SRC_ONE;
      7'b1_000_000: e.hidx = 3'd0;
      7'b1_000_001: e.hidx = 3'd1;
      7'b1_000_011: e.hidx = 3'd2;
      7'b1_001_000: e.hidx = 3'd3;
      7'b1_001_001: e.hidx = 3'd4;
      7'b1_001_011: e.hidx = 3'd5;
      7'b1_010_010: e.kind = SRC_ONE;
      7'b1_011_000: e.hidx = 3'd6;
      7'b1_011_001: e.hidx = 3'd7;
      7'b1_011_011: e.kind = SRC_ONE;
      default:      e.kind = SRC_ZERO;
    endcase
    return e;
  endfunction

endpackage

[rtl/fhs_if.sv]
// Valid/ready channel interfaces for point pairs and matrix slots.
// Depends on fhs_pkg.
interface fhs_in_if
  import fhs_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] src_x;
  logic signed [COORD_BITS-1:0] src_y;
  logic signed [COORD_BITS-1:0] dst_x;
  logic signed [COORD_BITS-1:0] dst_y;

  modport source (output valid, src_x, src_y, dst_x, dst_y, input ready);
  modport sink   (input valid, src_x, src_y, dst_x, dst_y, output ready);
endinterface

interface fhs_out_if
  import fhs_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [SLOT_W-1:0]       slot;
  logic signed [VAL_W-1:0] value;
  logic                    singular;
  logic                    last;

  modport source (output valid, slot, value, singular, last, input ready);
  modport sink   (input valid, slot, value, singular, last, output ready);
endinterface

[rtl/four_point_homography_solver.sv]
// Top level: point loader, elimination sequencer and slot emitter.
// Depends on fhs_pkg, fhs_if, fhs_mem, fhs_mul, fhs_div and the defines header.
//
// Each transfer on in_ch carries one point pair and the block then loads its two
// rows into the system memory. The fourth pair of a set then starts the solve: the
// sequencer walks the 8x9 system in memory (pivot search, row swaps, elimination,
// back substitution), one memory access per step, with a shared multiplier and a
// bit-serial divider. At most 36 divisions and about 200 multiplies set the solve
// time, after which slot_count slots, capped at 16, leave on out_ch, one per cycle
// when the sink is ready.
// No new pair is taken while a set is being solved or its slots are emitted.
`include "four_point_homography_solver_defines.svh"

module four_point_homography_solver
  import fhs_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fhs_in_if.sink                in_ch,
  fhs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int    PW      = 2 * COORD_BITS + 1;
  localparam word_t LIM     = SMAX >>> FRAC_BITS;
  localparam word_t ONE_FIX = word_t'(1) <<< FRAC_BITS;
  localparam logic signed [64:0] SMAX65 = {1'b0, SMAX};

  function automatic word_t sat_sub(word_t x, word_t y);
    logic signed [64:0] d;
    d = {x[63], x} - {y[63], y};
    if (d > SMAX65) return SMAX;
    if (d < -SMAX65) return -SMAX;
    return d[63:0];
  endfunction

  function automatic logic [63:0] magw(word_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic addr_t addr_of(logic [2:0] row, logic [3:0] col);
    return ADDR_W'(row * COLS + col);
  endfunction

  fhs_state_t state_r, state_nxt;

  logic signed [COORD_BITS-1:0] sx_r, sy_r, dx_r, dy_r;
  logic [1:0] pt_r, idx_r;
  logic       half_r;
  logic [3:0] col_r, k_r, r_r, j_r;
  logic [2:0] p_r;
  word_t      best_r, f_r, s_r, tk_r;
  word_t      x_r [ROWS];
  logic       ok_r, row_major_r;
  logic [4:0] slot_count_r, sl_r, total;
  logic [2:0] q_r;
  logic [1:0] m_r;
  logic       n4;

  logic                    out_valid_r, out_singular_r, out_last_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic signed [VAL_W-1:0] out_value_r;

  logic  mem_we, mem_re;
  addr_t mem_waddr, mem_raddr;
  word_t mem_wdata, rdata;
  logic  mul_start, mul_done, div_start, div_done;
  word_t mul_a, mul_b, mul_res, div_a, div_b, div_res;

  logic in_xfer, out_free, take, pcmp_last, p_swap;
  word_t best_fin;
  logic [2:0] p_fin;

  logic signed [COORD_BITS-1:0]   pa, pb;
  logic signed [2*COORD_BITS-1:0] prod;
  logic signed [PW-1:0]           tf_in;
  word_t tf_x, tf_v, ld_val;

  entry_t     ent;
  logic [2:0] er, ec, xa;
  word_t      xv;
  logic signed [VAL_W-1:0] emit_val;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign n4       = slot_count_r >= 5'd16;
  assign total    = (slot_count_r > 5'd16) ? 5'd16 : slot_count_r;

  // Point load datapath.
  always_comb begin
    pa    = col_r[0] ? sy_r : sx_r;
    pb    = half_r ? dy_r : dx_r;
    prod  = pa * pb;
    unique case (col_r)
      4'd0, 4'd3: tf_in = {{(PW-COORD_BITS){sx_r[COORD_BITS-1]}}, sx_r};
      4'd1, 4'd4: tf_in = {{(PW-COORD_BITS){sy_r[COORD_BITS-1]}}, sy_r};
      4'd6, 4'd7: tf_in = -{prod[2*COORD_BITS-1], prod};
      default:    tf_in = {{(PW-COORD_BITS){pb[COORD_BITS-1]}}, pb};
    endcase
    tf_x = {{(WORD_W-PW){tf_in[PW-1]}}, tf_in};
    if (tf_x > LIM) tf_v = SMAX;
    else if (tf_x < -LIM) tf_v = -SMAX;
    else tf_v = tf_x <<< FRAC_BITS;
    unique case (col_r)
      4'd0, 4'd1: ld_val = half_r ? '0 : tf_v;
      4'd2:       ld_val = half_r ? '0 : ONE_FIX;
      4'd3, 4'd4: ld_val = half_r ? tf_v : '0;
      4'd5:       ld_val = half_r ? ONE_FIX : '0;
      default:    ld_val = tf_v;
    endcase
  end

  // Pivot compare.
  always_comb begin
    take      = (r_r == k_r) || (magw(rdata) > magw(best_r));
    best_fin  = take ? rdata : best_r;
    p_fin     = take ? r_r[2:0] : p_r;
    pcmp_last = r_r == 4'd7;
    p_swap    = p_fin != k_r[2:0];
  end

  // Slot emit datapath.
  always_comb begin
    er  = row_major_r ? q_r : {1'b0, m_r};
    ec  = row_major_r ? {1'b0, m_r} : q_r;
    ent = entry_of(er, ec, n4);
    xa  = (state_r == S_B3) ? j_r[2:0] : ent.hidx;
    xv  = x_r[xa];
    unique case (ent.kind)
      SRC_H: begin
        if (!ok_r) emit_val = '0;
        else if (xv > VMAX64) emit_val = VMAX64[VAL_W-1:0];
        else if (xv < VMIN64) emit_val = VMIN64[VAL_W-1:0];
        else emit_val = xv[VAL_W-1:0];
      end
      SRC_ONE: emit_val = ONE_FIX[VAL_W-1:0];
      default: emit_val = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_LOAD;
      S_LOAD: if (col_r == 4'd8 && half_r) state_nxt = (idx_r == 2'd3) ? S_PRD : S_IDLE;
      S_PRD:  state_nxt = S_PCMP;
      S_PCMP: begin
        if (pcmp_last) begin
          if (best_fin == '0) state_nxt = S_EMIT;
          else if (p_swap) state_nxt = S_SW0;
          else state_nxt = S_E0;
        end else begin
          state_nxt = S_PRD;
        end
      end
      S_SW0:  state_nxt = S_SW1;
      S_SW1:  state_nxt = S_SW2;
      S_SW2:  state_nxt = S_SW3;
      S_SW3:  state_nxt = (j_r == 4'd8) ? S_E0 : S_SW0;
      S_E0: begin
        if (r_r == 4'd8) state_nxt = (k_r == 4'd7) ? S_B0 : S_PRD;
        else state_nxt = S_E1;
      end
      S_E1:   state_nxt = (rdata == '0) ? S_E0 : S_EDIV;
      S_EDIV: if (div_done) state_nxt = S_E2;
      S_E2:   state_nxt = S_E3;
      S_E3:   state_nxt = S_EMUL;
      S_EMUL: if (mul_done) state_nxt = (j_r == 4'd8) ? S_E0 : S_E2;
      S_B0:   state_nxt = S_B1;
      S_B1:   state_nxt = (k_r == 4'd7) ? S_B4 : S_B2;
      S_B2:   state_nxt = S_B3;
      S_B3:   state_nxt = S_BMUL;
      S_BMUL: if (mul_done) state_nxt = (j_r == 4'd7) ? S_B4 : S_B2;
      S_B4:   state_nxt = S_B5;
      S_B5:   state_nxt = S_BDIV;
      S_BDIV: if (div_done) state_nxt = (k_r == 4'd0) ? S_EMIT : S_B0;
      S_EMIT: if (sl_r == total) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready = state_r == S_IDLE;
    mem_we      = 1'b0;
    mem_waddr   = addr_of({half_r, idx_r}, col_r);
    mem_wdata   = ld_val;
    mem_re      = 1'b0;
    mem_raddr   = addr_of(k_r[2:0], j_r);
    mul_start   = 1'b0;
    mul_a       = f_r;
    mul_b       = rdata;
    div_start   = 1'b0;
    div_a       = rdata;
    div_b       = best_r;
    unique case (state_r)
      S_LOAD: mem_we = 1'b1;
      S_PRD: begin
        mem_re    = 1'b1;
        mem_raddr = addr_of(r_r[2:0], k_r);
      end
      S_SW0: mem_re = 1'b1;
      S_SW1: begin
        mem_re    = 1'b1;
        mem_raddr = addr_of(p_r, j_r);
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(k_r[2:0], j_r);
        mem_wdata = rdata;
      end
      S_SW3: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(p_r, j_r);
        mem_wdata = tk_r;
      end
      S_E0: begin
        mem_re    = r_r != 4'd8;
        mem_raddr = addr_of(r_r[2:0], k_r);
      end
      S_E1: div_start = rdata != '0;
      S_E2: mem_re = 1'b1;
      S_E3: begin
        mul_start = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = addr_of(r_r[2:0], j_r);
      end
      S_EMUL: begin
        mem_we    = mul_done;
        mem_waddr = addr_of(r_r[2:0], j_r);
        mem_wdata = sat_sub(rdata, mul_res);
      end
      S_B0: begin
        mem_re    = 1'b1;
        mem_raddr = addr_of(k_r[2:0], 4'd8);
      end
      S_B2: mem_re = 1'b1;
      S_B3: begin
        mul_start = 1'b1;
        mul_a     = rdata;
        mul_b     = xv;
      end
      S_B4: begin
        mem_re    = 1'b1;
        mem_raddr = addr_of(k_r[2:0], k_r);
      end
      S_B5: begin
        div_start = 1'b1;
        div_a     = s_r;
        div_b     = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pt_r         <= 2'd0;
      row_major_r  <= 1'b1;
      slot_count_r <= 5'd9;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_MAJOR:  row_major_r  <= cfg_wdata[0];
          CFG_SLOT_COUNT: slot_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            sx_r   <= in_ch.src_x;
            sy_r   <= in_ch.src_y;
            dx_r   <= in_ch.dst_x;
            dy_r   <= in_ch.dst_y;
            idx_r  <= pt_r;
            pt_r   <= pt_r + 2'd1;
            col_r  <= 4'd0;
            half_r <= 1'b0;
          end
        end
        S_LOAD: begin
          if (col_r == 4'd8) begin
            col_r  <= 4'd0;
            half_r <= 1'b1;
          end else begin
            col_r <= col_r + 4'd1;
          end
          k_r <= 4'd0;
          r_r <= 4'd0;
        end
        S_PCMP: begin
          best_r <= best_fin;
          p_r    <= p_fin;
          if (pcmp_last) begin
            if (best_fin == '0) begin
              ok_r <= 1'b0;
              sl_r <= 5'd0;
              q_r  <= 3'd0;
              m_r  <= 2'd0;
            end
            j_r <= k_r;
            r_r <= k_r + 4'd1;
          end else begin
            r_r <= r_r + 4'd1;
          end
        end
        S_SW1: tk_r <= rdata;
        S_SW3: j_r <= j_r + 4'd1;
        S_E0: begin
          if (r_r == 4'd8) begin
            k_r <= (k_r == 4'd7) ? 4'd7 : k_r + 4'd1;
            r_r <= (k_r == 4'd7) ? r_r : k_r + 4'd1;
          end
        end
        S_E1: if (rdata == '0) r_r <= r_r + 4'd1;
        S_EDIV: begin
          if (div_done) begin
            f_r <= div_res;
            j_r <= k_r + 4'd1;
          end
        end
        S_EMUL: begin
          if (mul_done) begin
            j_r <= j_r + 4'd1;
            if (j_r == 4'd8) r_r <= r_r + 4'd1;
          end
        end
        S_B1: begin
          s_r <= rdata;
          j_r <= k_r + 4'd1;
        end
        S_BMUL: begin
          if (mul_done) begin
            s_r <= sat_sub(s_r, mul_res);
            j_r <= j_r + 4'd1;
          end
        end
        S_BDIV: begin
          if (div_done) begin
            x_r[k_r[2:0]] <= div_res;
            k_r           <= k_r - 4'd1;
            ok_r          <= 1'b1;
            sl_r          <= 5'd0;
            q_r           <= 3'd0;
            m_r           <= 2'd0;
          end
        end
        S_EMIT: begin
          if (sl_r != total && out_free) begin
            out_valid_r    <= 1'b1;
            out_slot_r     <= sl_r[SLOT_W-1:0];
            out_value_r    <= emit_val;
            out_singular_r <= !ok_r;
            out_last_r     <= (sl_r + 5'd1) == total;
            sl_r           <= sl_r + 5'd1;
            if (m_r == (n4 ? 2'd3 : 2'd2)) begin
              m_r <= 2'd0;
              q_r <= q_r + 3'd1;
            end else begin
              m_r <= m_r + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.slot     = out_slot_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.singular = out_singular_r;
  assign out_ch.last     = out_last_r;

  fhs_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  fhs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  fhs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .res   (div_res)
  );

  `FHS_ASSERT(a_div_nonzero, div_start |-> (div_b != '0), "divide started with zero divisor")
  `FHS_ASSERT(a_no_idle_write, mem_we |-> (state_r != S_IDLE), "system write while idle")
  `FHS_ASSERT_NEXT(a_last_drains, out_ch.valid && out_ch.ready && out_ch.last, !out_ch.valid, "slot after last")

endmodule

[rtl/fhs_mem.sv]
// Augmented system store: 72 words, one write and one registered read port.
// Depends on fhs_pkg.
module fhs_mem
  import fhs_pkg::*;
(
  input  logic  clk,
  input  logic  we,
  input  addr_t waddr,
  input  word_t wdata,
  input  logic  re,
  input  addr_t raddr,
  output word_t rdata
);

  word_t mem [MEM_DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/fhs_mul.sv]
// Fixed-point multiply, round half away from zero, saturate; 32x32 partial products.
// Depends on fhs_pkg.
module fhs_mul
  import fhs_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  output logic  done,
  output word_t res
);

  localparam logic [127:0] HALF = 128'd1 << (FRAC_BITS - 1);

  logic [63:0]  am_r, bm_r, pp_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r, neg_r, done_r;
  word_t        res_r;
  logic [127:0] pp_sh;
  logic [31:0]  a_half, b_half;
  logic [63:0]  rm;

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
    a_half = cnt_r[1] ? am_r[63:32] : am_r[31:0];
    b_half = cnt_r[0] ? bm_r[63:32] : bm_r[31:0];
    rm = (|acc_r[127:FRAC_BITS+63]) ? SMAX : {1'b0, acc_r[FRAC_BITS+62:FRAC_BITS]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        am_r   <= a[63] ? 64'(-a) : 64'(a);
        bm_r   <= b[63] ? 64'(-b) : 64'(b);
        neg_r  <= a[63] ^ b[63];
        acc_r  <= '0;
        cnt_r  <= 3'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r <= 3'd3) begin
          pp_r <= a_half * b_half;
          sh_r <= 2'(cnt_r[1]) + 2'(cnt_r[0]);
          if (cnt_r != 3'd0) begin
            acc_r <= acc_r + pp_sh;
          end
        end else if (cnt_r == 3'd4) begin
          acc_r <= acc_r + pp_sh;
        end else if (cnt_r == 3'd5) begin
          acc_r <= acc_r + HALF;
        end else begin
          res_r  <= neg_r ? -word_t'(rm) : word_t'(rm);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[rtl/fhs_div.sv]
// Fixed-point divide a*2^F/b, one quotient bit per cycle, rounded and saturated.
// Depends on fhs_pkg.
module fhs_div
  import fhs_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t a,
  input  word_t b,
  output logic  done,
  output word_t res
);

  localparam int QW = WORD_W + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] num_r, q_r;
  logic [63:0]   rem_r, d_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, neg_r, done_r;
  word_t         res_r;
  logic [64:0]   rs;
  logic          ge, up;
  logic [QW:0]   qf;
  logic [63:0]   rm;

  always_comb begin
    rs = {rem_r, num_r[QW-1]};
    ge = rs >= {1'b0, d_r};
    up = rem_r >= (d_r - rem_r);
    qf = {1'b0, q_r} + (QW+1)'(up);
    rm = (|qf[QW:63]) ? SMAX : {1'b0, qf[62:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= QW'(a[63] ? 64'(-a) : 64'(a)) << FRAC_BITS;
        d_r    <= b[63] ? 64'(-b) : 64'(b);
        neg_r  <= a[63] ^ b[63];
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= ge ? 64'(rs - {1'b0, d_r}) : rs[63:0];
          q_r   <= {q_r[QW-2:0], ge};
          num_r <= {num_r[QW-2:0], 1'b0};
          cnt_r <= cnt_r - CW'(1);
        end else begin
          res_r  <= neg_r ? -word_t'(rm) : word_t'(rm);
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of four_point_homography_solver: point pairs in, matrix slots out.
// Depends on fhs_pkg, fhs_if and the solver RTL; predicts every slot in fixed point.
module tb_top
  import fhs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SETTLE    = 16000;
  localparam int  WD_LIMIT  = 200000;
  localparam int  LONG_HOLD = 3000;
  localparam logic [63:0] SMAXU = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint ONE_Q = 64'sd1 <<< 32;
  localparam int  SING_ANY = 2;

  typedef struct packed {
    logic signed [15:0] sx, sy, dx, dy;
  } pair_t;

  typedef struct {
    logic [3:0]  slot;
    logic [47:0] value;
    logic        singular;
    logic        last;
  } slot_rec_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fhs_in_if #(.COORD_BITS(16)) in_ch ();
  fhs_out_if out_ch ();

  four_point_homography_solver #(.COORD_BITS(16), .FRAC_BITS(32)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint    sys [8][9];
  longint    coef [8];
  int        pcount;
  bit        row_major_q;
  int        slots_q;
  slot_rec_t slot_q [$];
  int        sing_note_q [$];
  int        errors;
  bit        calm;
  bit        hold_req;
  int        idle_cycles;

  task automatic report(string what, longint exp_v, longint got_v);
    $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    errors++;
  endtask

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed_of(logic [63:0] m, bit neg);
    longint r;
    r = (m > SMAXU) ? SMAX : m;
    return neg ? -r : r;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    logic signed [65:0] s;
    s = a;
    s = s + b;
    if (s > SMAX) return SMAX;
    if (s < -SMAX) return -SMAX;
    return s[63:0];
  endfunction

  function automatic longint sat_sub_q(longint a, longint b);
    return sat_add(a, -b);
  endfunction

  function automatic longint mul_q(longint a, longint b);
    logic [127:0] p;
    logic [63:0] rl;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p + (128'd1 << 31);
    rl = p[95:32];
    if (p[127:96] != 0) rl = SMAXU;
    return signed_of(rl, (a < 0) != (b < 0));
  endfunction

  function automatic longint div_q(longint a, longint b);
    logic [127:0] nm, dd, q, rm;
    logic [63:0] rl;
    nm = {64'd0, mag64(a)} << 32;
    dd = {64'd0, mag64(b)};
    q  = nm / dd;
    rm = nm % dd;
    if (rm >= dd - rm) q = q + 1;
    rl = (q[127:64] != 0) ? SMAXU : q[63:0];
    return signed_of(rl, (a < 0) != (b < 0));
  endfunction

  function automatic longint to_q(longint v);
    if (v > 64'sd2147483647) return SMAX;
    if (v < -64'sd2147483647) return -SMAX;
    return v * ONE_Q;
  endfunction

  function automatic bit eliminate();
    longint x [8];
    longint t, f, s;
    int p;
    for (int k = 0; k < 8; k++) begin
      p = k;
      for (int r = k + 1; r < 8; r++)
        if (mag64(sys[r][k]) > mag64(sys[p][k])) p = r;
      if (sys[p][k] == 0) return 1'b0;
      if (p != k) begin
        for (int j = 0; j < 9; j++) begin
          t = sys[p][j]; sys[p][j] = sys[k][j]; sys[k][j] = t;
        end
      end
      for (int r = k + 1; r < 8; r++) begin
        if (sys[r][k] != 0) begin
          f = div_q(sys[r][k], sys[k][k]);
          for (int j = k + 1; j < 9; j++) sys[r][j] = sat_sub_q(sys[r][j], mul_q(f, sys[k][j]));
          sys[r][k] = 0;
        end
      end
    end
    for (int k = 7; k >= 0; k--) begin
      s = sys[k][8];
      for (int j = k + 1; j < 8; j++) s = sat_sub_q(s, mul_q(sys[k][j], x[j]));
      x[k] = div_q(s, sys[k][k]);
    end
    for (int k = 0; k < 8; k++)
      coef[k] = x[k] > VMAX64 ? VMAX64 : (x[k] < VMIN64 ? VMIN64 : x[k]);
    return 1'b1;
  endfunction

  function automatic void load_pair(pair_t pr, int note);
    longint sx, sy, dx, dy, v;
    longint mat [4][4];
    int i, n, total, q, m;
    bit ok;
    slot_rec_t rec;
    sx = pr.sx; sy = pr.sy; dx = pr.dx; dy = pr.dy;
    i = pcount;
    sys[i] = '{to_q(sx), to_q(sy), ONE_Q, 0, 0, 0, to_q(-(sx * dx)), to_q(-(sy * dx)), to_q(dx)};
    sys[i+4] = '{0, 0, 0, to_q(sx), to_q(sy), ONE_Q, to_q(-(sx * dy)), to_q(-(sy * dy)),
                 to_q(dy)};
    pcount = (i + 1) % 4;
    if (i != 3) return;
    ok = eliminate();
    if (!ok) coef = '{default: 0};
    n = slots_q >= 16 ? 4 : 3;
    mat = '{default: '{default: 0}};
    mat[0][0] = coef[0]; mat[0][1] = coef[1];
    mat[1][0] = coef[3]; mat[1][1] = coef[4];
    mat[2][2] = ONE_Q;
    mat[0][n-1] = coef[2]; mat[1][n-1] = coef[5];
    mat[n-1][0] = coef[6]; mat[n-1][1] = coef[7];
    mat[n-1][n-1] = ONE_Q;
    total = slots_q > 16 ? 16 : slots_q;
    for (int s = 0; s < total; s++) begin
      v = 0;
      if (s < n * n) begin
        q = s / n; m = s % n;
        v = row_major_q ? mat[q][m] : mat[m][q];
      end
      rec.slot = s[3:0];
      rec.value = v[47:0];
      rec.singular = (note == SING_ANY) ? !ok : note[0];
      rec.last = (s + 1 == total);
      slot_q.insert(slot_q.size(), rec);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      load_pair({in_ch.src_x, in_ch.src_y, in_ch.dst_x, in_ch.dst_y},
                pcount == 3 ? sing_note_q.pop_front() : SING_ANY);
  end

  always @(posedge clk) begin
    slot_rec_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (slot_q.size() == 0) begin
        report("unexpected slot", 0, out_ch.slot);
      end else begin
        e = slot_q.pop_front();
        if (out_ch.slot !== e.slot) report("slot", e.slot, out_ch.slot);
        if (out_ch.value !== e.value) report("value", e.value, out_ch.value);
        if (out_ch.singular !== e.singular) report("singular", e.singular, out_ch.singular);
        if (out_ch.last !== e.last) report("last", e.last, out_ch.last);
      end
    end
  end

  // sink side: random stall bursts, one long hold on request
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold = 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold = LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold > 0) begin
      hold--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("four_point_homography_solver regression: fail");
      $finish;
    end
  end

  task automatic offer(pair_t pr);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_x <= pr.sx;
    in_ch.src_y <= pr.sy;
    in_ch.dst_x <= pr.dx;
    in_ch.dst_y <= pr.dy;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_set(pair_t p0, pair_t p1, pair_t p2, pair_t p3, int note);
    sing_note_q.insert(sing_note_q.size(), note);
    offer(p0); offer(p1); offer(p2); offer(p3);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (slot_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_MAJOR) row_major_q = val[0];
    else slots_q = val[4:0];
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 600)) - 16'sd300;
      1: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic pair_t rnd_pair(int mode);
    pair_t p;
    p.sx = rnd_coord(mode); p.sy = rnd_coord(mode);
    p.dx = rnd_coord(mode); p.dy = rnd_coord(mode);
    return p;
  endfunction

  task automatic random_set();
    int kind;
    pair_t a, b, c, d;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      a = rnd_pair(0); b = rnd_pair(0); c = rnd_pair(0); d = rnd_pair(0);
    end else if (kind == 7) begin
      a = rnd_pair(1); b = rnd_pair(1); c = rnd_pair(1); d = rnd_pair(1);
    end else if (kind == 8) begin
      a = rnd_pair(0); b = a; c = rnd_pair(2); d = c;
    end else begin
      a = rnd_pair(2); b = rnd_pair(1); c = '0; d = rnd_pair(2);
    end
    send_set(a, b, c, d, SING_ANY);
  endtask

  pair_t dir_pairs [20] = '{
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd1, 16'sd0, 16'sd1, 16'sd0},
    '{16'sd0, 16'sd1, 16'sd0, 16'sd1}, '{16'sd1, 16'sd1, 16'sd1, 16'sd1},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF},
    '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000},
    '{16'sd0, 16'sd0, 16'sd5, 16'sd5}, '{16'sd1, 16'sd1, 16'sd9, 16'sd2},
    '{16'sd2, 16'sd2, 16'sd3, 16'sd7}, '{16'sd3, 16'sd3, 16'sd1, 16'sd1},
    '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, '{16'sd1, 16'sd2, 16'sd3, 16'sd4},
    '{16'sd1, 16'sd2, 16'sd3, 16'sd4}, '{16'sd1, 16'sd2, 16'sd3, 16'sd4}
  };
  int dir_sing [5] = '{0, 1, SING_ANY, SING_ANY, 1};

  int phase_rm [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
  int phase_sc [8] = '{16, 1, 12, 0, 31, 17, 9, 3};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.src_x = '0; in_ch.src_y = '0; in_ch.dst_x = '0; in_ch.dst_y = '0;
    errors = 0;
    pcount = 0;
    row_major_q = 1'b1;
    slots_q = 9;
    calm = 1'b0;
    hold_req = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int s = 0; s < 5; s++)
      send_set(dir_pairs[4*s], dir_pairs[4*s+1], dir_pairs[4*s+2], dir_pairs[4*s+3],
               dir_sing[s]);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      cfg_write(CFG_ROW_MAJOR, phase_rm[ph]);
      cfg_write(CFG_SLOT_COUNT, phase_sc[ph]);
      calm = (ph == 7);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < 10; n++) begin
        random_set();
        if (ph == 4) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (slot_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("four_point_homography_solver regression: pass");
    end else begin
      $display("four_point_homography_solver regression: fail");
    end
    $finish;
  end
endmodule

[four_point_homography_solver.f]
+incdir+rtl
rtl/fhs_pkg.sv
rtl/fhs_if.sv
rtl/fhs_mem.sv
rtl/fhs_mul.sv
rtl/fhs_div.sv
rtl/four_point_homography_solver.sv
tb/sv/tb_top.sv
